>>> sv/bhex_pkg.sv
// ----------------------------------------------------------------------------
// bhex_pkg
// Types, constants and helpers shared by the Intel HEX encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bhex_pkg;

  localparam int unsigned FILL_W    = 5;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned HDR_BYTES = 4;
  localparam int unsigned MAX_CHARS = 60;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NL      = 8'h0A;
  localparam logic [7:0] TYPE_ADDR    = 8'h04;
  localparam logic [7:0] TYPE_END     = 8'h01;
  localparam logic [7:0] ADDR_REC_LEN = 8'h02;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COLON,
    PH_HI,
    PH_LO,
    PH_SUM_HI,
    PH_SUM_LO,
    PH_NL
  } phase_e;

  typedef enum logic [1:0] {
    REC_ADDR,
    REC_DATA,
    REC_END
  } rec_e;

  // records still owed for the current transfer, in emission order
  typedef struct packed {
    logic addr_pre;
    logic data;
    logic addr_post;
    logic end_rec;
  } pend_t;

  typedef struct packed {
    pend_t             pend;
    logic [15:0]       seg;
    logic [15:0]       start;
    logic [FILL_W-1:0] cnt;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else begin
      c = 8'h37 + {4'h0, nib};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> sv/bhex_in_if.sv
// ----------------------------------------------------------------------------
// bhex_in_if
// Input stream: one raw byte or an end-of-data marker per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bhex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

`default_nettype wire

>>> sv/bhex_out_if.sv
// ----------------------------------------------------------------------------
// bhex_out_if
// Output stream: one character of Intel HEX text per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bhex_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       last_of_run;
  logic       file_done;

  modport source (output valid, output ascii_char, output last_of_run, output file_done,
                  input ready);
  modport sink   (input valid, input ascii_char, input last_of_run, input file_done,
                  output ready);
endinterface

`default_nettype wire

>>> sv/bhex_emitter.sv
// ----------------------------------------------------------------------------
// bhex_emitter
// Record buffer memory and character sequencer: walks the records owed for
// one input transfer and sends them out one character per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bhex_emitter #(
  parameter int unsigned RECORD_BYTES = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  job_load_i,
  input  bhex_pkg::job_t       job_i,
  input  wire                  wr_en_i,
  input  wire [((RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1)-1:0] wr_addr_i,
  input  wire [7:0]            wr_data_i,
  output logic                 busy_o,
  bhex_out_if.source           out_o
);

  localparam int unsigned IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam int unsigned LW    = bhex_pkg::LEN_W;

  logic [7:0] mem [RECORD_BYTES];
  logic [7:0] rdata_q;
  logic       rd_en;
  logic [IDX_W-1:0] rd_addr;

  bhex_pkg::phase_e  phase_q, phase_d;
  bhex_pkg::rec_e    rec_q, rec_d;
  bhex_pkg::pend_t   pend_q, pend_d;
  logic [LW-1:0]     idx_q, idx_d;
  logic [LW-1:0]     len_q, len_d;
  logic [7:0]        sum_q, sum_d;
  logic [LW-1:0]     chars_q, chars_d;
  logic [15:0]       seg_q, seg_d;
  logic [15:0]       start_q, start_d;
  logic [bhex_pkg::FILL_W-1:0] cnt_q, cnt_d;

  logic       ov_q, ov_d;
  logic [7:0] oc_q, oc_d;
  logic       ol_q, ol_d;
  logic       of_q, of_d;

  logic [7:0] cur_byte;
  logic [7:0] chk;
  logic [7:0] ch;
  logic       emit, advance, at_cap, pend_left, last, done;

  // record buffer
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_comb begin
    cur_byte = rdata_q;
    unique case (rec_q)
      bhex_pkg::REC_ADDR: begin
        unique case (idx_q)
          6'd0:    cur_byte = bhex_pkg::ADDR_REC_LEN;
          6'd3:    cur_byte = bhex_pkg::TYPE_ADDR;
          6'd4:    cur_byte = seg_q[15:8];
          6'd5:    cur_byte = seg_q[7:0];
          default: cur_byte = 8'h00;
        endcase
      end
      bhex_pkg::REC_DATA: begin
        unique case (idx_q)
          6'd0:    cur_byte = {3'b000, cnt_q};
          6'd1:    cur_byte = start_q[15:8];
          6'd2:    cur_byte = start_q[7:0];
          6'd3:    cur_byte = 8'h00;
          default: cur_byte = rdata_q;
        endcase
      end
      bhex_pkg::REC_END: begin
        cur_byte = (idx_q == 6'd3) ? bhex_pkg::TYPE_END : 8'h00;
      end
      default: cur_byte = rdata_q;
    endcase
  end

  assign chk       = 8'h00 - sum_q;
  assign emit      = (phase_q != bhex_pkg::PH_IDLE);
  assign advance   = emit && (!ov_q || out_o.ready);
  assign at_cap    = (chars_q == LW'(bhex_pkg::MAX_CHARS - 1));
  assign pend_left = |pend_q;
  assign last      = at_cap || ((phase_q == bhex_pkg::PH_NL) && !pend_left);
  assign done      = (phase_q == bhex_pkg::PH_NL) && (rec_q == bhex_pkg::REC_END);
  assign busy_o    = pend_left || emit;
  assign rd_addr   = IDX_W'(idx_q - LW'(bhex_pkg::HDR_BYTES - 1));

  always_comb begin
    unique case (phase_q)
      bhex_pkg::PH_COLON:  ch = bhex_pkg::CHAR_COLON;
      bhex_pkg::PH_HI:     ch = bhex_pkg::hex_char(cur_byte[7:4]);
      bhex_pkg::PH_LO:     ch = bhex_pkg::hex_char(cur_byte[3:0]);
      bhex_pkg::PH_SUM_HI: ch = bhex_pkg::hex_char(chk[7:4]);
      bhex_pkg::PH_SUM_LO: ch = bhex_pkg::hex_char(chk[3:0]);
      bhex_pkg::PH_NL:     ch = bhex_pkg::CHAR_NL;
      default:             ch = 8'h00;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    rec_d   = rec_q;
    pend_d  = pend_q;
    idx_d   = idx_q;
    len_d   = len_q;
    sum_d   = sum_q;
    chars_d = chars_q;
    seg_d   = seg_q;
    start_d = start_q;
    cnt_d   = cnt_q;
    rd_en   = 1'b0;

    if (job_load_i) begin
      pend_d  = job_i.pend;
      seg_d   = job_i.seg;
      start_d = job_i.start;
      cnt_d   = job_i.cnt;
      chars_d = '0;
    end else if (!emit && pend_left) begin
      phase_d = bhex_pkg::PH_COLON;
      idx_d   = '0;
      sum_d   = '0;
      priority if (pend_q.addr_pre) begin
        rec_d = bhex_pkg::REC_ADDR;
        len_d = LW'(bhex_pkg::HDR_BYTES + 2);
        pend_d.addr_pre = 1'b0;
      end else if (pend_q.data) begin
        rec_d = bhex_pkg::REC_DATA;
        len_d = LW'(bhex_pkg::HDR_BYTES) + {1'b0, cnt_q};
        pend_d.data = 1'b0;
      end else if (pend_q.addr_post) begin
        rec_d = bhex_pkg::REC_ADDR;
        len_d = LW'(bhex_pkg::HDR_BYTES + 2);
        pend_d.addr_post = 1'b0;
      end else begin
        rec_d = bhex_pkg::REC_END;
        len_d = LW'(bhex_pkg::HDR_BYTES);
        pend_d.end_rec = 1'b0;
      end
    end else if (advance) begin
      chars_d = chars_q + 1'b1;
      unique case (phase_q)
        bhex_pkg::PH_COLON:  phase_d = bhex_pkg::PH_HI;
        bhex_pkg::PH_HI:     phase_d = bhex_pkg::PH_LO;
        bhex_pkg::PH_LO: begin
          sum_d = sum_q + cur_byte;
          if (idx_q == len_q - 1'b1) begin
            phase_d = bhex_pkg::PH_SUM_HI;
          end else begin
            phase_d = bhex_pkg::PH_HI;
            idx_d   = idx_q + 1'b1;
            rd_en   = (idx_q >= LW'(bhex_pkg::HDR_BYTES - 1));
          end
        end
        bhex_pkg::PH_SUM_HI: phase_d = bhex_pkg::PH_SUM_LO;
        bhex_pkg::PH_SUM_LO: phase_d = bhex_pkg::PH_NL;
        bhex_pkg::PH_NL:     phase_d = bhex_pkg::PH_IDLE;
        default:             phase_d = bhex_pkg::PH_IDLE;
      endcase
      // character limit per transfer reached: drop the rest
      if (at_cap) begin
        phase_d = bhex_pkg::PH_IDLE;
        pend_d  = '0;
      end
    end
  end

  always_comb begin
    ov_d = ov_q;
    oc_d = oc_q;
    ol_d = ol_q;
    of_d = of_q;
    if (advance) begin
      ov_d = 1'b1;
      oc_d = ch;
      ol_d = last;
      of_d = done;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bhex_pkg::PH_IDLE;
      pend_q  <= '0;
      chars_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
      chars_q <= chars_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q   <= rec_d;
    idx_q   <= idx_d;
    len_q   <= len_d;
    sum_q   <= sum_d;
    seg_q   <= seg_d;
    start_q <= start_d;
    cnt_q   <= cnt_d;
    oc_q    <= oc_d;
    ol_q    <= ol_d;
    of_q    <= of_d;
  end

  assign out_o.valid       = ov_q;
  assign out_o.ascii_char  = oc_q;
  assign out_o.last_of_run = ol_q;
  assign out_o.file_done   = of_q;

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_load_i |-> !busy_o)
    else $error("job loaded while records still pending");

  a_chars_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chars_q <= LW'(bhex_pkg::MAX_CHARS))
    else $error("character count beyond limit");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == bhex_pkg::PH_HI || phase_q == bhex_pkg::PH_LO) |-> (idx_q < len_q))
    else $error("byte index beyond record length");

  a_done_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && done) |=> (out_o.last_of_run && out_o.ascii_char == bhex_pkg::CHAR_NL))
    else $error("end record not closed by last newline");

endmodule

`default_nettype wire

>>> sv/binary_to_intel_hex_encoder.sv
// ----------------------------------------------------------------------------
// binary_to_intel_hex_encoder
// Raw byte stream in, Intel HEX text out, one character per transfer.
// ----------------------------------------------------------------------------
// Each input transfer carries one byte or an end-of-data marker. A byte that
// owes no record is only written to the record buffer. A transfer that owes
// records is accepted, then each record gets a set-up step and 12 + 2n
// characters at one per cycle while the output takes them (n payload bytes;
// two for an address record), since the single character output port paces
// the block. The next input is taken as soon as the last character of a
// transfer sits in the output register. Characters beyond 60 for one
// transfer are dropped. After the end record every transfer is accepted and
// ignored until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_intel_hex_encoder #(
  parameter int unsigned RECORD_BYTES = 16
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  bhex_in_if.sink    in_i,
  bhex_out_if.source out_o
);

  localparam int unsigned IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam int unsigned FW    = bhex_pkg::FILL_W;

  logic [FW-1:0]               fill_q, fill_d;
  logic [bhex_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic                        started_q, started_d;
  logic                        finished_q, finished_d;

  logic [FW-1:0]               fill_inc;
  logic [bhex_pkg::ADDR_W-1:0] addr_inc;
  logic                        seg_wrap, full, accept, busy, job_load, wr_en;
  bhex_pkg::job_t              job;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = !busy;
  assign fill_inc = fill_q + 1'b1;
  assign addr_inc = addr_q + 1'b1;
  assign seg_wrap = (addr_inc[15:0] == 16'h0000);
  assign full     = ({1'b0, fill_inc} >= (FW + 1)'(RECORD_BYTES)) || (fill_inc == '0);
  assign wr_en    = accept && !finished_q && !in_i.end_of_data;
  assign job_load = accept && !finished_q && (|job.pend);

  always_comb begin
    job        = '0;
    job.seg    = addr_q[31:16];
    fill_d     = fill_q;
    addr_d     = addr_q;
    started_d  = started_q;
    finished_d = finished_q;
    if (!in_i.end_of_data) begin
      job.pend.addr_pre = !started_q;
      job.pend.data     = seg_wrap || full;
      job.cnt           = fill_inc;
      job.start         = addr_inc[15:0] - 16'(fill_inc);
      if (accept && !finished_q) begin
        fill_d    = (seg_wrap || full) ? '0 : fill_inc;
        addr_d    = addr_inc;
        started_d = !seg_wrap;
      end
    end else begin
      job.pend.data      = (fill_q != '0);
      job.pend.addr_post = !started_q;
      job.pend.end_rec   = 1'b1;
      job.cnt            = fill_q;
      job.start          = addr_q[15:0] - 16'(fill_q);
      if (accept && !finished_q) begin
        fill_d     = '0;
        started_d  = 1'b1;
        finished_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      addr_q     <= '0;
      started_q  <= 1'b0;
      finished_q <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      addr_q     <= addr_d;
      started_q  <= started_d;
      finished_q <= finished_d;
    end
  end

  bhex_emitter #(
    .RECORD_BYTES(RECORD_BYTES)
  ) u_emitter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_load_i (job_load),
    .job_i      (job),
    .wr_en_i    (wr_en),
    .wr_addr_i  (fill_q[IDX_W-1:0]),
    .wr_data_i  (in_i.data_byte),
    .busy_o     (busy),
    .out_o      (out_o)
  );

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, fill_q} < (FW + 1)'(RECORD_BYTES)))
    else $error("open record holds too many bytes");

  a_finish_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> (fill_q == '0 && started_q))
    else $error("state left behind after end record");

  a_finish_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |=> (finished_q && $stable(addr_q)))
    else $error("state changed after end record");

endmodule

`default_nettype wire

>>> sim/binary_to_intel_hex_encoder_tb.sv
// ----------------------------------------------------------------------------
// binary_to_intel_hex_encoder_tb
// Drives raw bytes and end-of-data markers into the encoder and checks
// every HEX character against a cycle-free model of the record framing:
// address records, 16-byte data records, the final flush and end record,
// and transfers ignored after the end.
// ----------------------------------------------------------------------------

module binary_to_intel_hex_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RECORD_BYTES  = 16;
  localparam logic [7:0]  REC_TYPE_DATA = 8'h00;
  localparam int unsigned HOLD_CYCLES   = 400;

  typedef struct {
    logic [7:0] ascii;
    logic       last;
    logic       done;
  } hex_char_t;

  logic clk;
  logic rst_n;

  bhex_in_if  in_bus ();
  bhex_out_if out_bus ();

  binary_to_intel_hex_encoder #(
    .RECORD_BYTES(RECORD_BYTES)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // encoder state as seen by the predictor
  logic [7:0]  rec_buf [RECORD_BYTES];
  int unsigned rec_fill;
  logic [31:0] next_addr;
  logic        seg_announced;
  logic        eof_written;

  logic [7:0]  line_bytes [4 + RECORD_BYTES];
  int unsigned item_chars;
  hex_char_t   hex_text_q [$];

  int unsigned mismatch_count;
  logic        sender_idle;
  int unsigned burst_left;
  int unsigned hold_len;
  int unsigned hold_seq;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + {4'h0, nib};
    end
    return 8'h41 + {4'h0, nib} - 8'd10;
  endfunction

  function automatic void push_char(input logic [7:0] c, input logic done);
    hex_char_t e;
    if (item_chars < bhex_pkg::MAX_CHARS) begin
      e.ascii = c;
      e.last  = 1'b0;
      e.done  = done;
      hex_text_q.push_back(e);
      item_chars++;
    end
  endfunction

  function automatic void push_byte(input logic [7:0] v);
    push_char(hex_digit(v[7:4]), 1'b0);
    push_char(hex_digit(v[3:0]), 1'b0);
  endfunction

  function automatic void push_line(input int unsigned len, input logic done);
    logic [7:0] sum;
    sum = 8'd0;
    push_char(bhex_pkg::CHAR_COLON, 1'b0);
    for (int unsigned i = 0; i < len; i++) begin
      sum += line_bytes[i];
      push_byte(line_bytes[i]);
    end
    push_byte(8'd0 - sum);
    push_char(bhex_pkg::CHAR_NL, done);
  endfunction

  function automatic void push_addr_record();
    line_bytes[0] = bhex_pkg::ADDR_REC_LEN;
    line_bytes[1] = 8'd0;
    line_bytes[2] = 8'd0;
    line_bytes[3] = bhex_pkg::TYPE_ADDR;
    line_bytes[4] = next_addr[31:24];
    line_bytes[5] = next_addr[23:16];
    push_line(6, 1'b0);
  endfunction

  function automatic void push_data_record();
    logic [31:0] first_addr;
    first_addr    = next_addr - rec_fill;
    line_bytes[0] = 8'(rec_fill);
    line_bytes[1] = first_addr[15:8];
    line_bytes[2] = first_addr[7:0];
    line_bytes[3] = REC_TYPE_DATA;
    for (int unsigned i = 0; i < rec_fill; i++) begin
      line_bytes[4 + i] = rec_buf[i];
    end
    push_line(4 + rec_fill, 1'b0);
    rec_fill = 0;
  endfunction

  function automatic void encode_item(input logic [7:0] b, input logic eod);
    hex_char_t tail;
    if (eof_written) begin
      return;
    end
    item_chars = 0;
    if (!eod) begin
      if (!seg_announced) begin
        push_addr_record();
        seg_announced = 1'b1;
      end
      rec_buf[rec_fill] = b;
      rec_fill++;
      next_addr++;
      if (next_addr[15:0] == 16'h0000) begin
        push_data_record();
        seg_announced = 1'b0;
      end else if (rec_fill >= RECORD_BYTES) begin
        push_data_record();
      end
    end else begin
      if (rec_fill > 0) begin
        push_data_record();
      end
      if (!seg_announced) begin
        push_addr_record();
        seg_announced = 1'b1;
      end
      line_bytes[0] = 8'd0;
      line_bytes[1] = 8'd0;
      line_bytes[2] = 8'd0;
      line_bytes[3] = bhex_pkg::TYPE_END;
      push_line(4, 1'b1);
      eof_written = 1'b1;
    end
    if (item_chars > 0) begin
      tail = hex_text_q.pop_back();
      tail.last = 1'b1;
      hex_text_q.push_back(tail);
    end
  endfunction

  // ------------------------------------------------------------------ sender
  task automatic send_item(input logic [7:0] b, input logic eod);
    if (sender_idle && burst_left == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    in_bus.valid       <= 1'b1;
    in_bus.data_byte   <= b;
    in_bus.end_of_data <= eod;
    do @(posedge clk); while (!in_bus.ready);
    encode_item(b, eod);
  endtask

  // ---------------------------------------------------------------- receiver
  initial begin
    int unsigned hold_left;
    int unsigned seen_seq;
    int unsigned tick;
    logic [15:0] pattern;
    hold_left = 0;
    seen_seq  = 0;
    tick      = 0;
    pattern   = '1;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = hold_len;
      end
      if (tick % 128 == 0) begin
        pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                              : 16'($urandom()) | 16'($urandom());
      end
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= pattern[0];
      end
      pattern = {pattern[0], pattern[15:1]};
    end
  end

  // ----------------------------------------------------------------- checker
  initial begin
    hex_char_t exp_c;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        if (hex_text_q.size() == 0) begin
          $error("unexpected character %h", out_bus.ascii_char);
          mismatch_count++;
        end else begin
          exp_c = hex_text_q.pop_front();
          if (out_bus.ascii_char !== exp_c.ascii) begin
            $error("ascii_char: expected %h, got %h", exp_c.ascii, out_bus.ascii_char);
            mismatch_count++;
          end
          if (out_bus.last_of_run !== exp_c.last) begin
            $error("last_of_run: expected %b, got %b", exp_c.last, out_bus.last_of_run);
            mismatch_count++;
          end
          if (out_bus.file_done !== exp_c.done) begin
            $error("file_done: expected %b, got %b", exp_c.done, out_bus.file_done);
            mismatch_count++;
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------- tests
  // first transfer announces segment 0; bit extremes fill and close a record
  task automatic test_directed_bytes();
    logic [7:0] pat [20];
    pat = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'h0F, 8'hF0,
            8'h12, 8'h34, 8'h9A, 8'hBC, 8'hDE, 8'hEF, 8'hFF, 8'hFF, 8'h00, 8'hC3};
    sender_idle = 1'b0;
    foreach (pat[i]) begin
      send_item(pat[i], 1'b0);
    end
  endtask

  task automatic test_random_bytes();
    sender_idle = 1'b1;
    burst_left  = 0;
    repeat (80) begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // long receiver hold-off with the sender pushing back to back
  task automatic test_output_stall();
    sender_idle = 1'b0;
    hold_len <= HOLD_CYCLES;
    hold_seq <= hold_seq + 1;
    repeat (48) begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic test_end_of_data();
    sender_idle = 1'b1;
    burst_left  = 0;
    send_item(8'hFF, 1'b1);
  endtask

  // everything after the end record is swallowed
  task automatic test_after_end();
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b1);
    for (int i = 0; i < 6; i++) begin
      send_item(8'($urandom_range(0, 255)), i[0]);
    end
  endtask

  initial begin
    rec_fill       = 0;
    next_addr      = '0;
    seg_announced  = 1'b0;
    eof_written    = 1'b0;
    item_chars     = 0;
    mismatch_count = 0;
    sender_idle    = 1'b0;
    burst_left     = 0;
    hold_len       = 0;
    hold_seq       = 0;
    in_bus.valid       <= 1'b0;
    in_bus.data_byte   <= 8'h00;
    in_bus.end_of_data <= 1'b0;
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_bytes();
    test_random_bytes();
    test_output_stall();
    test_end_of_data();
    test_after_end();

    in_bus.valid <= 1'b0;
    while (hex_text_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (100) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
